// ----- hdl/dual_touch_report_decoder_assert.svh -----
// Assertion macros shared by the touch report decoder modules.
`ifndef DUAL_TOUCH_REPORT_DECODER_ASSERT_SVH
`define DUAL_TOUCH_REPORT_DECODER_ASSERT_SVH

// Same-cycle implication.
`define DTRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtrd assertion failed");

// Next-cycle implication.
`define DTRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtrd assertion failed");

`endif

// ----- hdl/dtrd_pkg.sv -----
// Types and constants shared by the touch report decoder modules.
package dtrd_pkg;

   localparam int COORD_W    = 16;
   localparam int PRESS_W    = 8;
   localparam int SLOT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COORD_W-1:0] X_LIMIT_RST = 16'd2274;
   localparam logic [COORD_W-1:0] Y_LIMIT_RST = 16'd1274;
   localparam logic               MIRROR_RST  = 1'b1;
   localparam logic               SINGLE_RST  = 1'b0;

   typedef enum logic [2:0] {
      OFS_Y_HI,
      OFS_Y_LO,
      OFS_X_HI,
      OFS_X_LO,
      OFS_PRESSURE,
      OFS_TIP_ID
   } byte_ofs_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LIMIT,
      CSR_Y_LIMIT,
      CSR_MIRROR_AXES,
      CSR_SINGLE_TOUCH
   } csr_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
      logic [PRESS_W-1:0] pressure;
      logic [3:0]         track_id;
      logic [3:0]         tip;
   } finger_type;

   typedef struct packed {
      logic               touched;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PRESS_W-1:0] pressure;
   } slot_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_limit;
      logic [COORD_W-1:0] y_limit;
      logic               mirror_axes;
      logic               single_touch_mode;
   } cfg_type;

   typedef struct packed {
      logic report_done;
      logic at_last_byte;
   } cap_status_type;

endpackage

// ----- hdl/dtrd_capture.sv -----
// Report byte capture: position tracking, finger registers, pressure scaling.
`include "dual_touch_report_decoder_assert.svh"

module dtrd_capture #(
   parameter int FINGER_COUNT = 2,
   parameter int SENSITIVITY  = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       byte_xfer,
   input  logic [7:0]                                 report_byte,
   input  logic                                       report_start,
   output dtrd_pkg::cap_status_type                   status,
   output dtrd_pkg::finger_type [FINGER_COUNT-1:0]    fingers
);
   import dtrd_pkg::*;

   localparam int IDX_W     = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
   localparam int PRESS_DIV = SENSITIVITY - 5;

   typedef logic [255:0][PRESS_W-1:0] pressure_lut_type;

   function automatic pressure_lut_type build_pressure_lut();
      pressure_lut_type lut;
      int               sq;
      for (int p = 0; p < 256; p++) begin
         sq = (p * p) / PRESS_DIV;
         lut[p] = (sq > 255) ? 8'd255 : 8'(sq);
      end
      return lut;
   endfunction

   localparam pressure_lut_type PRESSURE_LUT = build_pressure_lut();

   logic                               active_ff, active_in;
   logic [IDX_W-1:0]                   finger_idx_ff, finger_idx_in;
   byte_ofs_type                       offset_ff, offset_in;
   logic                               done_ff, done_in;
   finger_type [FINGER_COUNT-1:0]      finger_ff;
   logic                               last_byte;
   logic                               payload_wr;

   assign last_byte  = active_ff && (finger_idx_ff == IDX_W'(FINGER_COUNT - 1)) &&
                       (offset_ff == OFS_TIP_ID);
   assign payload_wr = byte_xfer && !report_start && active_ff;

   always_comb begin
      active_in     = active_ff;
      finger_idx_in = finger_idx_ff;
      offset_in     = offset_ff;
      done_in       = 1'b0;
      if (byte_xfer) begin
         if (report_start) begin
            active_in     = 1'b1;
            finger_idx_in = '0;
            offset_in     = OFS_Y_HI;
         end else if (active_ff) begin
            if (last_byte) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end else if (offset_ff == OFS_TIP_ID) begin
               offset_in     = OFS_Y_HI;
               finger_idx_in = finger_idx_ff + 1'b1;
            end else begin
               offset_in = byte_ofs_type'(offset_ff + 3'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         finger_idx_ff <= '0;
         offset_ff     <= OFS_Y_HI;
         done_ff       <= 1'b0;
      end else begin
         active_ff     <= active_in;
         finger_idx_ff <= finger_idx_in;
         offset_ff     <= offset_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (payload_wr) begin
         case (offset_ff)
            OFS_Y_HI:     finger_ff[finger_idx_ff].y[15:8]  <= report_byte;
            OFS_Y_LO:     finger_ff[finger_idx_ff].y[7:0]   <= report_byte;
            OFS_X_HI:     finger_ff[finger_idx_ff].x[15:8]  <= report_byte;
            OFS_X_LO:     finger_ff[finger_idx_ff].x[7:0]   <= report_byte;
            OFS_PRESSURE: finger_ff[finger_idx_ff].pressure <= PRESSURE_LUT[report_byte];
            OFS_TIP_ID: begin
               finger_ff[finger_idx_ff].track_id <= report_byte[7:4];
               finger_ff[finger_idx_ff].tip      <= report_byte[3:0];
            end
            default: ;
         endcase
      end
   end

   assign status.report_done  = done_ff;
   assign status.at_last_byte = last_byte;
   assign fingers             = finger_ff;

   `DTRD_ASSERT_NEXT(a_done_single_pulse, clock, reset, done_ff, !done_ff)
   `DTRD_ASSERT_IMPLY(a_done_leaves_idle, clock, reset, done_ff, !active_ff)

endmodule

// ----- hdl/dtrd_decode.sv -----
// Finger-to-slot routing and coordinate adjustment for one finished report.
module dtrd_decode #(
   parameter int FINGER_COUNT = 2
) (
   input  dtrd_pkg::finger_type [FINGER_COUNT-1:0]                  fingers,
   input  dtrd_pkg::cfg_type                                        cfg,
   output dtrd_pkg::slot_type [FINGER_COUNT-1:0]                    slots,
   output logic                                                     emit_any,
   output logic [((FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1)-1:0] emit_last
);
   import dtrd_pkg::*;

   localparam int IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;

   function automatic logic [COORD_W-1:0] adjust_axis(
      input logic [COORD_W-1:0] v,
      input logic [COORD_W-1:0] lim,
      input logic               mirror
   );
      logic [COORD_W-1:0] m;
      if (mirror) begin
         m = (v > lim) ? lim : (lim - v);
      end else begin
         m = v;
      end
      return (m > lim) ? lim : m;
   endfunction

   finger_type [FINGER_COUNT-1:0] routed;
   logic       [FINGER_COUNT-1:0] routed_on;

   // later fingers override earlier ones for the same slot
   always_comb begin
      for (int s = 0; s < FINGER_COUNT; s++) begin
         routed[s]    = '0;
         routed_on[s] = 1'b0;
         for (int i = 0; i < FINGER_COUNT; i++) begin
            if ((fingers[i].tip != 4'd0) && ({28'd0, fingers[i].track_id} == s + 1)) begin
               routed[s]    = fingers[i];
               routed_on[s] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < FINGER_COUNT; s++) begin
         slots[s] = '0;
         if (routed_on[s]) begin
            slots[s].touched  = 1'b1;
            slots[s].pressure = routed[s].pressure;
            if (cfg.single_touch_mode) begin
               slots[s].x = routed[s].x;
               slots[s].y = routed[s].y;
            end else begin
               slots[s].x = adjust_axis(routed[s].x, cfg.x_limit, cfg.mirror_axes);
               slots[s].y = adjust_axis(routed[s].y, cfg.y_limit, cfg.mirror_axes);
            end
         end
      end
   end

   assign emit_any  = cfg.single_touch_mode ? routed_on[0] : 1'b1;
   assign emit_last = cfg.single_touch_mode ? '0 : IDX_W'(FINGER_COUNT - 1);

endmodule

// ----- hdl/dtrd_queue.sv -----
// Slot result buffer, drained one result per transfer in slot order.
`include "dual_touch_report_decoder_assert.svh"

module dtrd_queue #(
   parameter int FINGER_COUNT = 2
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     load,
   input  dtrd_pkg::slot_type [FINGER_COUNT-1:0]                    slots,
   input  logic                                                     emit_any,
   input  logic [((FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1)-1:0] emit_last,
   output logic                                                     head_valid,
   input  logic                                                     head_ready,
   output dtrd_pkg::slot_type                                       head,
   output logic [dtrd_pkg::SLOT_W-1:0]                              head_slot,
   output logic                                                     head_last
);
   import dtrd_pkg::*;

   localparam int IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
   localparam int NUM_W = IDX_W + SLOT_W;

   slot_type [FINGER_COUNT-1:0] buf_ff;
   logic                        pending_ff, pending_in;
   logic [IDX_W-1:0]            ptr_ff, ptr_in;
   logic [IDX_W-1:0]            last_ff, last_in;
   logic [NUM_W-1:0]            slot_num_wide;

   always_comb begin
      pending_in = pending_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      if (load) begin
         pending_in = emit_any;
         ptr_in     = '0;
         last_in    = emit_last;
      end else if (pending_ff && head_ready) begin
         if (ptr_ff == last_ff) begin
            pending_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         ptr_ff     <= '0;
         last_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         ptr_ff     <= ptr_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= slots;
      end
   end

   assign slot_num_wide = NUM_W'(ptr_ff) + NUM_W'(1);
   assign head_valid    = pending_ff;
   assign head          = buf_ff[ptr_ff];
   assign head_slot     = slot_num_wide[SLOT_W-1:0];
   assign head_last     = (ptr_ff == last_ff);

   `DTRD_ASSERT_IMPLY(a_load_into_empty, clock, reset, load, !pending_ff)
   `DTRD_ASSERT_IMPLY(a_ptr_within_last, clock, reset, pending_ff, ptr_ff <= last_ff)

endmodule

// ----- hdl/dual_touch_report_decoder.sv -----
// Top level of the two-finger touch report decoder.
// One report byte is taken per cycle. Each report is a header byte plus six
// bytes per finger; pressure is scaled through a 256-entry table as its byte
// arrives. The cycle after a report's final byte the fingers are routed to
// slots and adjusted into a slot buffer, from which the results leave one per
// cycle while rsp_ready is high: FINGER_COUNT results in multi-touch mode,
// zero or one in single-touch mode. Input stalls only on a report's final
// byte while results of the previous report are still queued. Configuration
// writes take effect on the next cycle.
`include "dual_touch_report_decoder_assert.svh"

module dual_touch_report_decoder #(
   parameter int FINGER_COUNT = 2,
   parameter int SENSITIVITY  = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_report_byte,
   input  logic                                 req_report_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dtrd_pkg::SLOT_W-1:0]          rsp_slot_number,
   output logic                                 rsp_touched,
   output logic [dtrd_pkg::COORD_W-1:0]         rsp_x_position,
   output logic [dtrd_pkg::COORD_W-1:0]         rsp_y_position,
   output logic [dtrd_pkg::PRESS_W-1:0]         rsp_pressure_level,
   output logic                                 rsp_last_of_report,
   input  logic                                 csr_we,
   input  logic [dtrd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtrd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dtrd_pkg::*;

   localparam int IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;

   cfg_type                       cfg_ff, cfg_in;
   cap_status_type                cap_status;
   finger_type [FINGER_COUNT-1:0] fingers;
   slot_type   [FINGER_COUNT-1:0] slots;
   logic                          emit_any;
   logic [IDX_W-1:0]              emit_last;
   slot_type                      head;
   logic                          byte_xfer;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_X_LIMIT:      cfg_in.x_limit           = csr_wdata;
            CSR_Y_LIMIT:      cfg_in.y_limit           = csr_wdata;
            CSR_MIRROR_AXES:  cfg_in.mirror_axes       = csr_wdata[0];
            CSR_SINGLE_TOUCH: cfg_in.single_touch_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_limit           <= X_LIMIT_RST;
         cfg_ff.y_limit           <= Y_LIMIT_RST;
         cfg_ff.mirror_axes       <= MIRROR_RST;
         cfg_ff.single_touch_mode <= SINGLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !(rsp_valid && cap_status.at_last_byte);
   assign byte_xfer = req_valid && req_ready;

   dtrd_capture #(
      .FINGER_COUNT (FINGER_COUNT),
      .SENSITIVITY  (SENSITIVITY)
   ) u_capture (
      .clock        (clock),
      .reset        (reset),
      .byte_xfer    (byte_xfer),
      .report_byte  (req_report_byte),
      .report_start (req_report_start),
      .status       (cap_status),
      .fingers      (fingers)
   );

   dtrd_decode #(
      .FINGER_COUNT (FINGER_COUNT)
   ) u_decode (
      .fingers   (fingers),
      .cfg       (cfg_ff),
      .slots     (slots),
      .emit_any  (emit_any),
      .emit_last (emit_last)
   );

   dtrd_queue #(
      .FINGER_COUNT (FINGER_COUNT)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (cap_status.report_done),
      .slots      (slots),
      .emit_any   (emit_any),
      .emit_last  (emit_last),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready),
      .head       (head),
      .head_slot  (rsp_slot_number),
      .head_last  (rsp_last_of_report)
   );

   assign rsp_touched        = head.touched;
   assign rsp_x_position     = head.x;
   assign rsp_y_position     = head.y;
   assign rsp_pressure_level = head.pressure;

   `DTRD_ASSERT_IMPLY(a_stall_only_when_busy, clock, reset, !req_ready, rsp_valid)

endmodule
